// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while rst is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that is checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/irpd_pkg.sv =====
// Package with the types and constants of the IR pulse-distance decoder.
`timescale 1ns / 1ps

package irpd_pkg;

   localparam int unsigned TIME_W    = 32;
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned CODE_W    = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned BIT_CNT_W = 5;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_GAP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_MAX = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_MIN    = 2'd3;

   // Reset values of the configuration registers
   localparam logic [TICK_W-1:0] FRAME_GAP_RST  = 16'd500;
   localparam logic [TICK_W-1:0] LEADER_MIN_RST = 16'd224;
   localparam logic [TICK_W-1:0] LEADER_MAX_RST = 16'd298;
   localparam logic [TICK_W-1:0] ONE_MIN_RST    = 16'd32;

   // Index of the last of the 32 data bits
   localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'd31;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEADER,
      ST_DATA
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] frame_gap;
      logic [TICK_W-1:0] leader_min;
      logic [TICK_W-1:0] leader_max;
      logic [TICK_W-1:0] one_min;
   } cfg_type;

   typedef struct packed {
      logic              emit;
      logic [CODE_W-1:0] code;
   } result_type;

endpackage

// ===== rtl/core/irpd_interval.sv =====
// Input register stage: takes edge timestamps and registers the interval since the last edge.
`timescale 1ns / 1ps

module irpd_interval
   import irpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TIME_W-1:0] req_edge_time,
   input  logic              step,
   output logic              interval_vld,
   output logic [TIME_W-1:0] interval
);

   logic              vld_ff;
   logic              vld_in;
   logic [TIME_W-1:0] interval_ff;
   logic [TIME_W-1:0] interval_in;
   logic [TIME_W-1:0] last_time_ff;
   logic              accept;

   assign req_ready   = !vld_ff || step;
   assign accept      = req_valid && req_ready;
   assign interval_in = req_edge_time - last_time_ff;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (step) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= 1'b0;
         last_time_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         if (accept) begin
            last_time_ff <= req_edge_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         interval_ff <= interval_in;
      end
   end

   assign interval_vld = vld_ff;
   assign interval     = interval_ff;

endmodule

// ===== rtl/core/irpd_frame.sv =====
// Frame tracker: classes each interval and shifts data bits into the code word.
`timescale 1ns / 1ps

module irpd_frame
   import irpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic [TIME_W-1:0] interval,
   input  logic              step,
   output result_type        result
);

   phase_type              state_ff;
   phase_type              state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff;
   logic [BIT_CNT_W-1:0]   bit_cnt_in;
   logic [CODE_W-1:0]      shift_ff;
   logic [CODE_W-1:0]      shift_in;
   logic                   gap_hit;
   logic                   leader_ok;
   logic                   data_bit;

   assign gap_hit   = interval >= {{(TIME_W-TICK_W){1'b0}}, cfg.frame_gap};
   assign leader_ok = (interval >= {{(TIME_W-TICK_W){1'b0}}, cfg.leader_min}) &&
                      (interval <= {{(TIME_W-TICK_W){1'b0}}, cfg.leader_max});
   assign data_bit  = interval >= {{(TIME_W-TICK_W){1'b0}}, cfg.one_min};

   always_comb begin
      state_in    = state_ff;
      bit_cnt_in  = bit_cnt_ff;
      shift_in    = shift_ff;
      result.emit = 1'b0;
      result.code = {shift_ff[CODE_W-2:0], data_bit};
      if (gap_hit) begin
         // a long gap restarts the frame from any phase
         state_in = ST_LEADER;
         shift_in = '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
            end
            ST_LEADER: begin
               if (leader_ok) begin
                  state_in   = ST_DATA;
                  bit_cnt_in = '0;
               end
            end
            ST_DATA: begin
               shift_in = {shift_ff[CODE_W-2:0], data_bit};
               if (bit_cnt_ff == LAST_BIT) begin
                  result.emit = 1'b1;
                  state_in    = ST_LEADER;
               end else begin
                  bit_cnt_in = bit_cnt_ff + 1'b1;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         shift_ff   <= '0;
      end else if (step) begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
      end
   end

endmodule

// ===== rtl/core/irpd_out.sv =====
// Result register: holds a finished code word until the receiver takes it.
`timescale 1ns / 1ps

module irpd_out
   import irpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [CODE_W-1:0] code,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CODE_W-1:0] rsp_code_word
);

   logic              vld_ff;
   logic              vld_in;
   logic [CODE_W-1:0] code_ff;

   assign free = !vld_ff || rsp_ready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code;
      end
   end

   assign rsp_valid     = vld_ff;
   assign rsp_code_word = code_ff;

endmodule

// ===== rtl/core/ir_pulse_distance_decoder.sv =====
// IR pulse-distance decoder top level: config registers and the three pipeline parts.
//
// Usage:
//   req_* carries one transaction per falling edge of the IR receiver: req_edge_time is
//   the free-running 32-bit tick count at that edge. rsp_* carries one transaction per
//   completed frame: rsp_code_word is the 32-bit code, first bit received in bit 31.
//   Most edges produce no response; the edge that closes the last of 32 data bits after
//   a frame gap and a leader produces one, and after a frame the next leader starts a new code.
//   csr_* writes a threshold register (frame gap, leader min, leader max, one min);
//   write it only while the block is idle.
// Path: the last-bit transaction is registered in the interval register, and its
//   code word then in the result register, raising rsp_valid; a full one stalls it.
// Throughput: one edge per cycle unless a code word waits on a full result register,
//   set by the single registered pass through the interval register and the frame tracker.
// Reset: clears the pipeline, the frame phase, the last timestamp (the first interval
//   is taken from zero) and loads the default thresholds 500, 224, 298 and 32.
// Stall: while rsp_ready is low a finished code word is held in the result register;
//   edges that produce no response keep flowing, and req_ready drops only when a
//   second code word is ready and the result register is still full.
`timescale 1ns / 1ps

module ir_pulse_distance_decoder
   import irpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_W-1:0]    req_edge_time,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CODE_W-1:0]    rsp_code_word,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata
);

   cfg_type           cfg_ff;
   logic              interval_vld;
   logic [TIME_W-1:0] interval;
   logic              out_free;
   logic              step;
   result_type        result;

   // Threshold registers; the user must make writes only while no transaction is in flight (not checked).
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_gap  <= FRAME_GAP_RST;
         cfg_ff.leader_min <= LEADER_MIN_RST;
         cfg_ff.leader_max <= LEADER_MAX_RST;
         cfg_ff.one_min    <= ONE_MIN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_GAP:  cfg_ff.frame_gap  <= csr_wdata;
            CSR_LEADER_MIN: cfg_ff.leader_min <= csr_wdata;
            CSR_LEADER_MAX: cfg_ff.leader_max <= csr_wdata;
            CSR_ONE_MIN:    cfg_ff.one_min    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Advance the registered interval unless it carries a code word and the result
   // register cannot take it this cycle.
   assign step = interval_vld && (!result.emit || out_free);

   irpd_interval u_interval (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_edge_time (req_edge_time),
      .step          (step),
      .interval_vld  (interval_vld),
      .interval      (interval)
   );

   irpd_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .interval (interval),
      .step     (step),
      .result   (result)
   );

   irpd_out u_out (
      .clock         (clock),
      .reset         (reset),
      .load          (step && result.emit),
      .code          (result.code),
      .free          (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_word (rsp_code_word)
   );

endmodule

// ===== rtl/core/irpd_checker.sv =====
// Port-level checker for the IR pulse-distance decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irpd_checker
   import irpd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CODE_W-1:0] rsp_code_word
);

   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_word), "response dropped or changed while stalled")
   `ASSERT_RST(a_req_stall_cause, clock, reset, !req_ready |-> rsp_valid && !rsp_ready, "request stalled without a stalled response")
   `ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid && req_ready, "pipeline not empty after reset")

endmodule

bind ir_pulse_distance_decoder irpd_checker u_irpd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_code_word (rsp_code_word)
);
